>>> rtl/core/omrs_pkg.sv
// ----------------------------------------------------------------------------
// omrs_pkg
// Shared types and constants of the ordered multiset rank/select block.
// ----------------------------------------------------------------------------
package omrs_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int CMD_W         = 3;
  localparam int VALUE_W       = 32;
  localparam int RANK_W        = 16;
  localparam int COUNT_W       = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_RANK   = 3'd2,
    CMD_SELECT = 3'd3,
    CMD_PRED   = 3'd4,
    CMD_SUCC   = 3'd5,
    CMD_RSV6   = 3'd6,
    CMD_RSV7   = 3'd7
  } cmd_t;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

>>> rtl/core/omrs_mem.sv
// ----------------------------------------------------------------------------
// omrs_mem
// Entry memory: one key and its copy count per entry, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module omrs_mem #(
  parameter int DEPTH  = omrs_pkg::CAPACITY_DEF,
  parameter int KW     = omrs_pkg::KEY_WIDTH_DEF,
  parameter int AW     = 10
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [KW-1:0]                wkey,
  input  logic [omrs_pkg::COUNT_W-1:0] wcnt,
  input  logic [AW-1:0]                raddr,
  output logic [KW-1:0]                rkey,
  output logic [omrs_pkg::COUNT_W-1:0] rcnt
);
  import omrs_pkg::*;

  logic [KW+COUNT_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wkey, wcnt};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    {rkey, rcnt} <= mem[raddr];
  end

endmodule

>>> rtl/core/ordered_multiset_rank_select.sv
// ----------------------------------------------------------------------------
// ordered_multiset_rank_select
// Sorted table of distinct keys with copy counts, held in one memory.
// ----------------------------------------------------------------------------
// Usage: the in_ channel takes a command (insert, delete, rank, select,
// predecessor, successor) with in_value and in_rank_index. Insert and delete
// give no item; the four queries each give one item on the out_ channel with
// out_answer and the sticky out_overflowed flag.
// Each command is handled one at a time by a sequencer that scans the table
// from entry 0 through one memory read port (one entry per cycle, registered
// read). With N distinct keys stored, a query scans all N entries, then a
// decision state sets the output register and out_valid; no new item is
// taken until the current one is finished. A count update is written in
// place after the scan. An insert of a new key at position p then moves the
// N-p entries from p up, each by a read and then a write, and writes the new
// key at p; a delete of a last copy moves the N-1-p entries above p down,
// each by a read and then a write.
// Reset empties the table (fill count zero) and clears the overflow flag;
// no clearing pass is needed. The result sits in an output register; while
// the receiver stalls, the next item is not taken until it is delivered.
// ----------------------------------------------------------------------------
module ordered_multiset_rank_select #(
  parameter int CAPACITY  = omrs_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = omrs_pkg::KEY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [omrs_pkg::CMD_W-1:0]   in_command,
  input  logic signed [omrs_pkg::VALUE_W-1:0] in_value,
  input  logic [omrs_pkg::RANK_W-1:0]  in_rank_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [omrs_pkg::VALUE_W-1:0] out_answer,
  output logic                         out_overflowed
);
  import omrs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int TW = NW + COUNT_W;   // total element count width
  localparam int KW_IN = (KEY_WIDTH < VALUE_W) ? KEY_WIDTH : VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DONE, S_SHUP, S_SHDN, S_OUT
  } state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  logic signed [KEY_WIDTH-1:0] key_r;
  logic [RANK_W-1:0]    rk_r;
  logic [NW-1:0]        used_r;
  logic                 ovf_r;
  logic [NW-1:0]        idx_r;       // entry being requested
  logic                 rv_r;        // read data valid for entry idx_r-1
  logic [TW-1:0]        acc_r;       // prefix count
  logic signed [KEY_WIDTH-1:0] prev_r; // key of last entry below
  logic                 hasprev_r;
  logic                 found_r;
  logic [NW-1:0]        pos_r;       // lower position
  logic [COUNT_W-1:0]   cnt_r;       // count at pos
  logic signed [KEY_WIDTH-1:0] sel_r;
  logic                 selok_r;
  logic signed [KEY_WIDTH-1:0] succ_r;
  logic                 succok_r;
  logic [NW-1:0]        sidx_r;      // shift index
  logic                 sph_r;       // shift phase: 0 read, 1 write
  logic                 ov_r;
  logic signed [VALUE_W-1:0] ans_r;

  // memory ports
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [KEY_WIDTH-1:0] wkey, rkey;
  logic [COUNT_W-1:0]   wcnt, rcnt;

  omrs_mem #(.DEPTH(CAPACITY), .KW(KEY_WIDTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wkey(wkey), .wcnt(wcnt),
    .raddr(raddr), .rkey(rkey), .rcnt(rcnt)
  );

  logic signed [KEY_WIDTH-1:0] rkey_s, in_key;
  logic [TW-1:0]        acc_add;
  logic                 lt, eq;

  assign rkey_s  = $signed(rkey);
  assign acc_add = acc_r + TW'(rcnt);
  assign lt      = rkey_s < key_r;
  assign eq      = rkey_s == key_r;

  // operand key: sign-extend the low key bits
  assign in_key = KEY_WIDTH'($signed(in_value[KW_IN-1:0]));

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_answer     = ans_r;
  assign out_overflowed = ov_r;

  // memory access control
  always_comb begin
    we    = 1'b0;
    waddr = pos_r[AW-1:0];
    wkey  = key_r;
    wcnt  = cnt_r;
    raddr = idx_r[AW-1:0];
    unique case (state_r)
      S_SHUP: begin
        raddr = AW'(sidx_r - NW'(1));
        if (sph_r) begin
          we    = 1'b1;
          waddr = sidx_r[AW-1:0];
          wkey  = rkey;
          wcnt  = rcnt;
        end
      end
      S_SHDN: begin
        raddr = AW'(sidx_r + NW'(1));
        if (sph_r) begin
          we    = 1'b1;
          waddr = sidx_r[AW-1:0];
          wkey  = rkey;
          wcnt  = rcnt;
        end
      end
      S_DONE: begin
        // count update in place, or the new entry after an up-shift
        if (cmd_r == CMD_INSERT && found_r && cnt_r != COUNT_MAX) begin
          we   = 1'b1;
          wcnt = cnt_r + COUNT_W'(1);
        end else if (cmd_r == CMD_DELETE && found_r && cnt_r > COUNT_W'(1)) begin
          we   = 1'b1;
          wcnt = cnt_r - COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      ovf_r   <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= cmd_t'(in_command);
            key_r     <= in_key;
            rk_r      <= in_rank_index;
            idx_r     <= '0;
            rv_r      <= 1'b0;
            acc_r     <= '0;
            hasprev_r <= 1'b0;
            found_r   <= 1'b0;
            pos_r     <= used_r;
            cnt_r     <= '0;
            selok_r   <= 1'b0;
            succok_r  <= 1'b0;
            if (in_command == CMD_RSV6 || in_command == CMD_RSV7) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // evaluate entry idx_r-1 whose data just arrived
          if (rv_r) begin
            if (lt) begin
              prev_r    <= rkey_s;
              hasprev_r <= 1'b1;
            end else if (pos_r == used_r) begin
              pos_r   <= idx_r - NW'(1);
              found_r <= eq;
              cnt_r   <= rcnt;
              if (!eq) begin
                succ_r <= rkey_s; succok_r <= 1'b1;
              end
            end else if (!succok_r && found_r) begin
              succ_r <= rkey_s; succok_r <= 1'b1;
            end
            if (!selok_r && rk_r != '0 && TW'(rk_r) <= acc_add) begin
              sel_r   <= rkey_s;
              selok_r <= 1'b1;
            end
            // select counts every entry, rank only those below the key
            acc_r <= (lt || cmd_r == CMD_SELECT) ? acc_add : acc_r;
          end
          if (idx_r < used_r) begin
            idx_r <= idx_r + NW'(1);
            rv_r  <= 1'b1;
          end else begin
            rv_r    <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          priority case (cmd_r)
            CMD_INSERT: begin
              if (found_r) begin
                if (cnt_r == COUNT_MAX) ovf_r <= 1'b1;
                state_r <= S_IDLE;
              end else if (used_r >= NW'(CAPACITY)) begin
                ovf_r   <= 1'b1;
                state_r <= S_IDLE;
              end else begin
                sidx_r  <= used_r;
                sph_r   <= 1'b0;
                state_r <= S_SHUP;
              end
            end
            CMD_DELETE: begin
              if (found_r && cnt_r == COUNT_W'(1)) begin
                sidx_r  <= pos_r;
                sph_r   <= 1'b0;
                state_r <= S_SHDN;
              end else begin
                state_r <= S_IDLE;
              end
            end
            default: begin
              ov_r <= ovf_r;
              priority case (cmd_r)
                CMD_RANK: begin
                  if (acc_r + TW'(found_r) > TW'(32'h7FFF_FFFF)) begin
                    ans_r <= 32'sh7FFF_FFFF;
                  end else begin
                    ans_r <= VALUE_W'(acc_r + TW'(found_r));
                  end
                end
                CMD_SELECT: ans_r <= selok_r ? VALUE_W'(sel_r) : '0;
                CMD_PRED:   ans_r <= hasprev_r ? VALUE_W'(prev_r) : '0;
                default:    ans_r <= succok_r ? VALUE_W'(succ_r) : '0;
              endcase
              state_r <= S_OUT;
            end
          endcase
        end
        S_SHUP: begin
          // move entry sidx-1 to sidx, down to pos, then write the new key
          if (sidx_r == pos_r) begin
            found_r <= 1'b1;
            cmd_r   <= CMD_INSERT;
            used_r  <= used_r + NW'(1);
            cnt_r   <= '0;
            state_r <= S_DONE;
          end else if (sph_r) begin
            sidx_r <= sidx_r - NW'(1);
            sph_r  <= 1'b0;
          end else begin
            sph_r <= 1'b1;
          end
        end
        S_SHDN: begin
          if (sidx_r + NW'(1) >= used_r) begin
            used_r  <= used_r - NW'(1);
            state_r <= S_IDLE;
          end else if (sph_r) begin
            sidx_r <= sidx_r + NW'(1);
            sph_r  <= 1'b0;
          end else begin
            sph_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // fill count never exceeds capacity
  a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NW'(CAPACITY)) else $error("fill count above capacity");
  // overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r) else $error("overflow flag cleared");
  // result waits while receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_answer))
    else $error("result dropped under stall");
  // no item taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered multiset rank/select block. A queue of
// commands feeds a clocked driver; a clocked monitor keeps a sorted copy of
// the multiset, predicts every query answer and checks each result item.
// ----------------------------------------------------------------------------
module tb_top;
  import omrs_pkg::*;

  localparam int CAP       = 1024;
  localparam int STALL_MAX = 20000;
  localparam int DRAIN_CYC = 4000;

  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] val;
    logic [15:0]        rk;
    bit                 hold;
  } cmd_item_t;

  typedef struct {
    logic signed [31:0] answer;
    logic               ovf;
  } answer_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_overflowed;
  logic [CMD_W-1:0] in_command;
  logic signed [VALUE_W-1:0] in_value, out_answer;
  logic [RANK_W-1:0] in_rank_index;

  cmd_item_t pending_q[$];
  answer_t   answer_q[$];

  // sorted distinct keys with copy counts, as the block should hold them
  logic signed [31:0] mset_keys[$];
  int unsigned        mset_counts[$];
  bit                 mset_ovf;

  int errors;
  int sent;
  int idle_cycles;

  ordered_multiset_rank_select dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_value(in_value), .in_rank_index(in_rank_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_answer(out_answer), .out_overflowed(out_overflowed)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // first index whose key is not below k
  function automatic int lower_index(logic signed [31:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = mset_keys.size();
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (mset_keys[mid] < k) lo = mid + 1; else hi = mid;
    end
    return lo;
  endfunction

  // apply one command to the multiset; returns 1 when it answers
  function automatic bit apply_command(cmd_item_t it, output answer_t res);
    int p, q;
    longint total;
    bit found;
    p = lower_index(it.val);
    found = (p < mset_keys.size()) && (mset_keys[p] == it.val);
    res.answer = '0;
    case (it.cmd)
      CMD_INSERT: begin
        if (found) begin
          if (mset_counts[p] >= 65535) mset_ovf = 1'b1;
          else mset_counts[p]++;
        end else if (mset_keys.size() >= CAP) begin
          mset_ovf = 1'b1;
        end else begin
          mset_keys.insert(p, it.val);
          mset_counts.insert(p, 1);
        end
        return 1'b0;
      end
      CMD_DELETE: begin
        if (found) begin
          if (mset_counts[p] > 1) mset_counts[p]--;
          else begin
            mset_keys.delete(p);
            mset_counts.delete(p);
          end
        end
        return 1'b0;
      end
      CMD_RANK: begin
        total = 0;
        for (int i = 0; i < p; i++) total += mset_counts[i];
        if (found) total++;
        if (total > 64'sh7FFF_FFFF) total = 64'sh7FFF_FFFF;
        res.answer = total[31:0];
      end
      CMD_SELECT: begin
        total = 0;
        if (it.rk != 0) begin
          for (int i = 0; i < mset_keys.size(); i++) begin
            total += mset_counts[i];
            if (it.rk <= total) begin
              res.answer = mset_keys[i];
              break;
            end
          end
        end
      end
      CMD_PRED: begin
        if (p > 0) res.answer = mset_keys[p-1];
      end
      CMD_SUCC: begin
        q = found ? p + 1 : p;
        if (q < mset_keys.size()) res.answer = mset_keys[q];
      end
      default: return 1'b0;
    endcase
    res.ovf = mset_ovf;
    return 1'b1;
  endfunction

  // idle percentages per phase of the run
  function automatic int sender_idle_pct();
    if (sent < 550) return 27;
    if (sent < 1100) return 88;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (sent < 550) return 88;
    if (sent < 1100) return 27;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    cmd_item_t nxt;
    bit take;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_command    <= CMD_INSERT;
      in_value      <= '0;
      in_rank_index <= '0;
      out_ready     <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
      if (!in_valid || in_ready) begin
        take = 1'b0;
        if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          take = !pending_q[0].hold || (!in_valid && answer_q.size() == 0);
        end
        if (take) begin
          nxt = pending_q.pop_front();
          in_valid      <= 1'b1;
          in_command    <= nxt.cmd;
          in_value      <= nxt.val;
          in_rank_index <= nxt.rk;
          sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on each accepted item, check each result item
  always @(posedge clk) begin
    cmd_item_t it;
    answer_t res, exp_res;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        idle_cycles = 0;
        it.cmd  = cmd_t'(in_command);
        it.val  = in_value;
        it.rk   = in_rank_index;
        it.hold = 1'b0;
        if (apply_command(it, res)) answer_q.push_back(res);
      end
      if (out_valid && out_ready) begin
        idle_cycles = 0;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected item answer=%0d overflowed=%0b",
                   $time, out_answer, out_overflowed);
          errors++;
        end else begin
          exp_res = answer_q.pop_front();
          if (out_answer !== exp_res.answer) begin
            $display("%0t: answer expected %0d actual %0d",
                     $time, exp_res.answer, out_answer);
            errors++;
          end
          if (out_overflowed !== exp_res.ovf) begin
            $display("%0t: overflowed expected %0b actual %0b",
                     $time, exp_res.ovf, out_overflowed);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_MAX) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic push_item(cmd_t c, logic signed [31:0] v, logic [15:0] r,
                           bit h = 1'b0);
    cmd_item_t it;
    it.cmd  = c;
    it.val  = v;
    it.rk   = r;
    it.hold = h;
    pending_q.push_back(it);
  endtask

  task automatic wait_accepted();
    do @(posedge clk);
    while (pending_q.size() > 0 || in_valid);
  endtask

  function automatic logic signed [31:0] random_value();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $signed($urandom_range(24)) - 12;
    if (r < 85) begin
      case ($urandom_range(4))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7FFF_FFFF;
        3: return 32'sh7FFF_FFFE;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int r;
    cmd_t c;
    logic [15:0] rk;
    errors = 0;
    sent = 0;
    idle_cycles = 0;
    mset_ovf = 1'b0;

    // directed: extremes, every command, empty-store and absent-key cases
    push_item(CMD_SELECT, 0, 16'd1);
    push_item(CMD_PRED, 0, 0);
    push_item(CMD_INSERT, 32'sh8000_0000, 0);
    push_item(CMD_INSERT, 32'sh7FFF_FFFF, 0);
    push_item(CMD_INSERT, 0, 0);
    push_item(CMD_INSERT, 0, 0);
    push_item(CMD_RANK, 32'sh8000_0000, 0);
    push_item(CMD_RANK, 32'sh7FFF_FFFF, 0);
    push_item(CMD_RANK, 5, 0);
    push_item(CMD_SELECT, 0, 16'd0);
    push_item(CMD_SELECT, 0, 16'd3);
    push_item(CMD_SELECT, 0, 16'd4);
    push_item(CMD_SELECT, 0, 16'd5);
    push_item(CMD_SELECT, 0, 16'hFFFF);
    push_item(CMD_PRED, 32'sh8000_0000, 0);
    push_item(CMD_SUCC, 32'sh7FFF_FFFF, 0);
    push_item(CMD_PRED, 32'sh7FFF_FFFF, 0);
    push_item(CMD_SUCC, 32'sh8000_0000, 0);
    push_item(CMD_DELETE, 77, 0);
    push_item(CMD_DELETE, 0, 0);
    push_item(CMD_RANK, 0, 0);
    push_item(CMD_RSV6, 32'sh5555_5555, 16'hAAAA);
    push_item(CMD_RSV7, 32'shAAAA_AAAA, 16'h5555);
    push_item(CMD_SUCC, 0, 0);

    // random commands, mostly on a small key pool so keys repeat
    for (int n = 0; n < 440; n++) begin
      r = $urandom_range(99);
      if (r < 36) c = CMD_INSERT;
      else if (r < 56) c = CMD_DELETE;
      else if (r < 68) c = CMD_RANK;
      else if (r < 80) c = CMD_SELECT;
      else if (r < 89) c = CMD_PRED;
      else if (r < 98) c = CMD_SUCC;
      else c = ($urandom_range(1)) ? CMD_RSV6 : CMD_RSV7;
      rk = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(80));
      // hold back one item until no query result is outstanding
      push_item(c, random_value(), rk, n == 200);
    end
    wait_accepted();

    // empty the store, then store one key
    for (int i = mset_keys.size() - 1; i >= 0; i--)
      for (int j = 0; j < mset_counts[i]; j++)
        push_item(CMD_DELETE, mset_keys[i], 0);
    push_item(CMD_SELECT, 0, 16'd1);
    push_item(CMD_INSERT, 5, 0);
    push_item(CMD_RANK, 6, 0);
    push_item(CMD_SELECT, 0, 16'hFFFF);

    // fill the store to capacity, then try one more new key
    for (int n = 0; n < CAP - 1; n++) push_item(CMD_INSERT, 1000 + n, 0);
    push_item(CMD_INSERT, 7, 0);
    push_item(CMD_SUCC, 5, 0);
    push_item(CMD_PRED, 1000, 0);
    push_item(CMD_RANK, 32'sh7FFF_FFFF, 0);
    push_item(CMD_SELECT, 0, 16'hFFFF);
    push_item(CMD_DELETE, 1000 + CAP - 2, 0);
    push_item(CMD_PRED, 32'sh7FFF_FFFF, 0);
    wait_accepted();

    while (answer_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
